/* rtl/dsrc_pkg.sv */
package dsrc_pkg;

  localparam int DEF_LINE_CAPACITY = 32;
  localparam int DEF_ID_DIGITS     = 9;

  localparam int TIMER_W = 16;
  localparam int VALUE_W = 30;
  localparam int CFG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY    = 3'd4;

  localparam logic [TIMER_W-1:0] RST_DEBOUNCE = 16'd50;
  localparam logic [TIMER_W-1:0] RST_LOCKOUT  = 16'd1500;
  localparam logic [TIMER_W-1:0] RST_TIMEOUT  = 16'd5000;
  localparam logic [TIMER_W-1:0] RST_DISPLAY  = 16'd2000;
  localparam logic [TIMER_W-1:0] RST_RELAY    = 16'd3000;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WAIT = 3'b010,
    MODE_SHOW = 3'b100
  } mode_t;

  typedef struct packed {
    logic [TIMER_W-1:0] settle_ms;
    logic [TIMER_W-1:0] lockout_ms;
    logic [TIMER_W-1:0] reply_wait_ms;
    logic [TIMER_W-1:0] display_ms;
    logic [TIMER_W-1:0] relay_hold_ms;
  } cfg_t;

  // complete reply line seen on this byte
  typedef struct packed {
    logic               hit;
    logic               nonzero;
    logic [VALUE_W-1:0] value;
  } line_evt_t;

  typedef struct packed {
    logic               timed_out;
    logic [VALUE_W-1:0] id_value;
    logic               id_valid;
    logic               relay_on;
    logic               red_led;
    logic               green_led;
    logic               send_request;
  } res_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
    return (t == TIMER_MAX) ? t : t + TIMER_W'(1);
  endfunction

endpackage

/* rtl/door_scan_request_controller_unit.sv */
// channel  dir  tuser       tdata (lowest bit first)
// s_axis   in   cmd         trigger_level, rx_byte, pad
// m_axis   out  -           send_request, green_led, red_led, relay_on,
//                           id_valid, id_value[29:0], timed_out, pad
// cfg      in   -           cfg_we, cfg_index (3b), cfg_data (16b)
//
// One word per cycle sustained while m_tready stays high.
// Word goes input register -> tick/line logic -> result register.
// rst (sync) clears state, registers go to defaults, both stages empty.
// m_tready low holds the result register; the input register still fills,
// so one more word is taken before s_tready drops.
module door_scan_request_controller_unit
  import dsrc_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int ID_DIGITS     = DEF_ID_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // trigger_level, rx_byte[7:0], zero pad
  input  logic                 s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // send_request, green_led, red_led, relay_on,
                                          // id_valid, id_value[29:0], timed_out, pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data
);

  localparam int RES_W = $bits(res_t);

  cfg_t       cfg;
  logic       in_v;
  logic       in_cmd;
  logic       in_trig;
  logic [7:0] in_byte;
  logic       adv;
  line_evt_t  evt;
  res_t       res;
  res_t       out_res;

  assign adv      = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{RST_DEBOUNCE, RST_LOCKOUT, RST_TIMEOUT, RST_DISPLAY, RST_RELAY};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.settle_ms     <= cfg_data;
        REG_LOCKOUT:  cfg.lockout_ms    <= cfg_data;
        REG_TIMEOUT:  cfg.reply_wait_ms <= cfg_data;
        REG_DISPLAY:  cfg.display_ms    <= cfg_data;
        REG_RELAY:    cfg.relay_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_trig <= s_tdata[0];
      in_byte <= s_tdata[8:1];
    end
  end

  dsrc_line #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .ID_DIGITS    (ID_DIGITS)
  ) u_line (
    .clk    (clk),
    .rst    (rst),
    .en     (adv && in_cmd == CMD_BYTE),
    .rx_byte(in_byte),
    .evt    (evt)
  );

  dsrc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .cmd          (in_cmd),
    .trigger_level(in_trig),
    .evt          (evt),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(40 - RES_W)'(0), out_res};

endmodule

/* rtl/dsrc_line.sv */
module dsrc_line
  import dsrc_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int ID_DIGITS     = DEF_ID_DIGITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic [7:0] rx_byte,
  output line_evt_t evt
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  logic [LEN_W-1:0]   len, len_next;
  logic               all_dig, all_dig_next;
  logic               nz, nz_next;
  logic [VALUE_W-1:0] value, value_next;
  logic               is_digit;
  logic [VALUE_W-1:0] digit;

  assign is_digit = rx_byte inside {[CHAR_0:CHAR_9]};
  assign digit    = VALUE_W'(rx_byte - CHAR_0);

  always_comb begin
    len_next     = len;
    all_dig_next = all_dig;
    nz_next      = nz;
    value_next   = value;
    evt          = '0;
    if (rx_byte == CHAR_CR) begin
      // dropped
    end else if (rx_byte == CHAR_LF) begin
      evt.hit      = (len != '0) && (32'(len) == ID_DIGITS) && all_dig;
      evt.nonzero  = nz;
      evt.value    = value;
      len_next     = '0;
      all_dig_next = 1'b1;
      nz_next      = 1'b0;
      value_next   = '0;
    end else if (len < LEN_LIMIT) begin
      if (!is_digit) begin
        all_dig_next = 1'b0;
      end else if (32'(len) < ID_DIGITS) begin
        value_next = (value << 3) + (value << 1) + digit;
        nz_next    = nz | (digit != '0);
      end
      len_next = len + LEN_W'(1);
    end else begin
      len_next     = '0;
      all_dig_next = 1'b1;
      nz_next      = 1'b0;
      value_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      all_dig <= 1'b1;
      nz      <= 1'b0;
      value   <= '0;
    end else if (en) begin
      len     <= len_next;
      all_dig <= all_dig_next;
      nz      <= nz_next;
      value   <= value_next;
    end
  end

endmodule

/* rtl/dsrc_ctrl.sv */
module dsrc_ctrl
  import dsrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      cmd,
  input  logic      trigger_level,
  input  line_evt_t evt,
  input  cfg_t      cfg,
  output res_t      res
);

  mode_t              mode, mode_next;
  logic [TIMER_W-1:0] mode_timer, mode_timer_next;
  logic [TIMER_W-1:0] since_edge, since_edge_next;
  logic [TIMER_W-1:0] since_req, since_req_next;
  logic               raw_prev, raw_prev_next;
  logic               stable, stable_next;
  logic               green, green_next;
  logic               red, red_next;
  logic               relay, relay_next;

  always_comb begin
    mode_next       = mode;
    mode_timer_next = mode_timer;
    since_edge_next = since_edge;
    since_req_next  = since_req;
    raw_prev_next   = raw_prev;
    stable_next     = stable;
    green_next      = green;
    red_next        = red;
    relay_next      = relay;
    res             = '0;
    if (cmd == CMD_TICK) begin
      mode_timer_next = sat_inc(mode_timer);
      since_edge_next = sat_inc(since_edge);
      since_req_next  = sat_inc(since_req);
      if (trigger_level != raw_prev) begin
        since_edge_next = '0;
        raw_prev_next   = trigger_level;
      end
      if (since_edge_next > cfg.settle_ms && stable != trigger_level) begin
        stable_next = trigger_level;
        if (!trigger_level && mode == MODE_IDLE && since_req_next > cfg.lockout_ms) begin
          res.send_request = 1'b1;
          mode_next        = MODE_WAIT;
          mode_timer_next  = '0;
          since_req_next   = '0;
          green_next       = 1'b0;
          red_next         = 1'b0;
        end
      end
      if (mode_next == MODE_WAIT && mode_timer_next > cfg.reply_wait_ms) begin
        green_next      = 1'b0;
        red_next        = 1'b1;
        mode_next       = MODE_SHOW;
        mode_timer_next = '0;
        res.timed_out   = 1'b1;
      end else if (mode_next == MODE_SHOW) begin
        if (mode_timer_next > cfg.relay_hold_ms) begin
          relay_next = 1'b0;
        end
        if (mode_timer_next > cfg.display_ms) begin
          mode_next       = MODE_IDLE;
          mode_timer_next = '0;
          green_next      = 1'b0;
          red_next        = 1'b0;
          relay_next      = 1'b0;
        end
      end
    end else if (evt.hit && mode == MODE_WAIT) begin
      green_next      = evt.nonzero;
      red_next        = !evt.nonzero;
      relay_next      = evt.nonzero;
      mode_next       = MODE_SHOW;
      mode_timer_next = '0;
      res.id_valid    = 1'b1;
      res.id_value    = evt.value;
    end
    res.green_led = green_next;
    res.red_led   = red_next;
    res.relay_on  = relay_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      mode_timer <= '0;
      since_edge <= '0;
      since_req  <= '0;
      raw_prev   <= 1'b1;
      stable     <= 1'b1;
      green      <= 1'b0;
      red        <= 1'b0;
      relay      <= 1'b0;
    end else if (en) begin
      mode       <= mode_next;
      mode_timer <= mode_timer_next;
      since_edge <= since_edge_next;
      since_req  <= since_req_next;
      raw_prev   <= raw_prev_next;
      stable     <= stable_next;
      green      <= green_next;
      red        <= red_next;
      relay      <= relay_next;
    end
  end

endmodule

/* rtl/dsrc_checker.sv */
module dsrc_checker
  import dsrc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [39:0]          m_tdata
);

  // a verified reply lights exactly one lamp and drives the relay with green
  a_reply_lamps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> (m_tdata[1] != m_tdata[2]) && (m_tdata[3] == m_tdata[1]))
    else $error("reply lamps inconsistent");

  a_timeout_red: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35] |-> m_tdata[2] && !m_tdata[1] && !m_tdata[4])
    else $error("timeout without red lamp");

  a_request_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[2] && !m_tdata[35] && !m_tdata[4])
    else $error("request with lamps on");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> m_tdata[34:5] == '0)
    else $error("id_value without id_valid");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

endmodule

bind door_scan_request_controller_unit dsrc_checker u_dsrc_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* dv/door_scan_request_controller_unit_test.sv */
module door_scan_request_controller_unit_test
  import dsrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  class door_outcome_sb;
    logic [TIMER_W-1:0] debounce_lim, lockout_lim, timeout_lim, display_lim, relay_lim;
    mode_t              mode;
    logic [TIMER_W-1:0] mode_ms, edge_ms, request_ms;
    logic               pin_last, pin_stable;
    int                 line_len;
    bit                 line_ok;
    logic [31:0]        line_num;
    logic               green, red, relay;
    res_t               expected_q[$];
    int                 mismatches;
    int                 seen;

    function new();
      debounce_lim = RST_DEBOUNCE;
      lockout_lim  = RST_LOCKOUT;
      timeout_lim  = RST_TIMEOUT;
      display_lim  = RST_DISPLAY;
      relay_lim    = RST_RELAY;
      mode         = MODE_IDLE;
      mode_ms      = '0;
      edge_ms      = '0;
      request_ms   = '0;
      pin_last     = 1'b1;
      pin_stable   = 1'b1;
      green        = 1'b0;
      red          = 1'b0;
      relay        = 1'b0;
      mismatches   = 0;
      seen         = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len = 0;
      line_ok  = 1'b1;
      line_num = '0;
    endfunction

    function logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] t);
      return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] val);
      case (idx)
        REG_DEBOUNCE: debounce_lim = val;
        REG_LOCKOUT:  lockout_lim  = val;
        REG_TIMEOUT:  timeout_lim  = val;
        REG_DISPLAY:  display_lim  = val;
        REG_RELAY:    relay_lim    = val;
        default: ;
      endcase
    endfunction

    function void note_word(logic cmd, logic lvl, logic [7:0] ch);
      res_t r;
      r = '0;
      if (cmd == CMD_TICK) begin
        mode_ms    = bump(mode_ms);
        edge_ms    = bump(edge_ms);
        request_ms = bump(request_ms);
        if (lvl != pin_last) begin
          edge_ms  = '0;
          pin_last = lvl;
        end
        if (edge_ms > debounce_lim && pin_stable != lvl) begin
          pin_stable = lvl;
          if (!lvl && mode == MODE_IDLE && request_ms > lockout_lim) begin
            r.send_request = 1'b1;
            mode       = MODE_WAIT;
            mode_ms    = '0;
            request_ms = '0;
            green      = 1'b0;
            red        = 1'b0;
          end
        end
        if (mode == MODE_WAIT && mode_ms > timeout_lim) begin
          green       = 1'b0;
          red         = 1'b1;
          mode        = MODE_SHOW;
          mode_ms     = '0;
          r.timed_out = 1'b1;
        end else if (mode == MODE_SHOW) begin
          if (mode_ms > relay_lim) relay = 1'b0;
          if (mode_ms > display_lim) begin
            mode    = MODE_IDLE;
            mode_ms = '0;
            green   = 1'b0;
            red     = 1'b0;
            relay   = 1'b0;
          end
        end
      end else if (ch == CHAR_LF) begin
        if (mode == MODE_WAIT && line_len == DEF_ID_DIGITS && line_ok) begin
          green      = (line_num != 0);
          red        = (line_num == 0);
          relay      = green;
          mode       = MODE_SHOW;
          mode_ms    = '0;
          r.id_valid = 1'b1;
          r.id_value = line_num[VALUE_W-1:0];
        end
        clear_line();
      end else if (ch != CHAR_CR) begin
        if (line_len < DEF_LINE_CAPACITY - 1) begin
          if (ch < CHAR_0 || ch > CHAR_9) line_ok = 1'b0;
          else if (line_len < DEF_ID_DIGITS) line_num = line_num * 10 + (ch - CHAR_0);
          line_len++;
        end else begin
          clear_line();
        end
      end
      r.green_led = green;
      r.red_led   = red;
      r.relay_on  = relay;
      expected_q.push_back(r);
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_word(logic [39:0] w);
      res_t got, want;
      got = res_t'(w[35:0]);
      seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $error("result word with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      field("send_request", want.send_request, got.send_request);
      field("green_led",    want.green_led,    got.green_led);
      field("red_led",      want.red_led,      got.red_led);
      field("relay_on",     want.relay_on,     got.relay_on);
      field("id_valid",     want.id_valid,     got.id_valid);
      field("id_value",     want.id_value,     got.id_value);
      field("timed_out",    want.timed_out,    got.timed_out);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;   // trigger_level, rx_byte[7:0], zero pad
  logic                 s_tuser;   // cmd
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;   // send_request, green_led, red_led, relay_on,
                                   // id_valid, id_value[29:0], timed_out, pad
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIMER_W-1:0]   cfg_data;

  door_outcome_sb sb = new();
  bit             gaps_on = 1'b1;
  int             words_sent = 0;
  int             cfg_now[5];

  door_scan_request_controller_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[0], s_tdata[8:1]);
    end
  end

  // sink side: random stalls plus one long hold-off to back up the pipe
  initial begin
    int  pick;
    bit  held;
    held = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && sb.seen >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (250) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 4) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (pick == 4) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #(400_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] digit();
    return 8'(CHAR_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return 8'h00;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CHAR_0 && c <= CHAR_9) || c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  task automatic push_word(logic cmd, logic lvl, logic [7:0] ch);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, ch, lvl};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic tick(logic lvl);
    push_word(CMD_TICK, lvl, 8'($urandom_range(0, 255)));
  endtask

  task automatic ticks(logic lvl, int n);
    repeat (n) tick(lvl);
  endtask

  task automatic rx(logic [7:0] ch);
    push_word(CMD_BYTE, 1'($urandom_range(0, 1)), ch);
  endtask

  task automatic send_reply(int n, bit zero_id, bit spoil);
    int bad;
    bad = spoil ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == bad) rx(non_digit());
      else rx(zero_id ? CHAR_0 : digit());
      if ($urandom_range(0, 15) == 0) rx(CHAR_CR);
    end
    if ($urandom_range(0, 1)) rx(CHAR_CR);
    rx(CHAR_LF);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(int db, int lo, int to, int disp, int rel);
    write_reg(REG_DEBOUNCE, TIMER_W'(db));
    write_reg(REG_LOCKOUT,  TIMER_W'(lo));
    write_reg(REG_TIMEOUT,  TIMER_W'(to));
    write_reg(REG_DISPLAY,  TIMER_W'(disp));
    write_reg(REG_RELAY,    TIMER_W'(rel));
    // indexes past the last register must be ignored
    for (int i = int'(REG_RELAY) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), TIMER_W'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    cfg_now = '{db, lo, to, disp, rel};
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 5))
        0, 1: tick(1'($urandom_range(0, 1)));
        2: rx(CHAR_LF);
        3: rx(digit());
        default: rx(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic press_episode();
    int kind;
    kind = $urandom_range(0, 9);
    gaps_on = ($urandom_range(0, 4) != 0);
    repeat ($urandom_range(0, 3)) tick(1'($urandom_range(0, 1)));
    ticks(1'b0, cfg_now[0] + 2 + $urandom_range(0, 2));
    ticks(1'($urandom_range(0, 1)), $urandom_range(0, cfg_now[2]));
    case (kind)
      6: begin
        if ($urandom_range(0, 1)) send_reply(DEF_ID_DIGITS, 1'b0, 1'b1);
        else send_reply(DEF_ID_DIGITS - 1 + 2 * $urandom_range(0, 1), 1'b0, 1'b0);
        send_reply(DEF_ID_DIGITS, 1'b0, 1'b0);
      end
      7: ticks(1'b1, cfg_now[2] + 2);
      8: begin
        // overflow clears the line; the tail after it forms a fresh reply
        repeat (DEF_LINE_CAPACITY) rx(digit());
        send_reply(DEF_ID_DIGITS, 1'b0, 1'b0);
      end
      9: ;
      default: send_reply(DEF_ID_DIGITS, $urandom_range(0, 7) == 0, 1'b0);
    endcase
    ticks(1'b1, (cfg_now[3] > cfg_now[4] ? cfg_now[3] : cfg_now[4]) + 2
                + $urandom_range(0, 3));
    ticks(1'b1, $urandom_range(0, cfg_now[1] + 2));
  endtask

  task automatic run_phase(int n);
    int stop;
    stop = words_sent + n;
    while (words_sent < stop) begin
      if ($urandom_range(0, 4) == 0) noise_burst();
      else press_episode();
    end
    gaps_on = 1'b1;
    ticks(1'b1, cfg_now[2] + cfg_now[3] + 4);
    drain();
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= '0;
    cfg_now = '{int'(RST_DEBOUNCE), int'(RST_LOCKOUT), int'(RST_TIMEOUT),
                int'(RST_DISPLAY), int'(RST_RELAY)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: edge bytes, CR, a dropped line, an unsolicited reply
    tick(1'b0);
    tick(1'b1);
    rx(8'h00);
    rx(8'hFF);
    rx(CHAR_CR);
    rx(CHAR_LF);
    send_reply(DEF_ID_DIGITS, 1'b0, 1'b0);
    drain();

    set_config(1, 3, 6, 4, 2);
    ticks(1'b0, 3);
    rx(CHAR_LF);
    send_reply(DEF_ID_DIGITS, 1'b1, 1'b0);
    drain();

    set_config(0, 0, 0, 0, 0);
    run_phase(300);
    set_config(1, 6, 9, 5, 3);
    run_phase(420);
    set_config(4, 20, 25, 10, 14);
    run_phase(420);
    set_config(0, 5, 12, 3, 9);
    run_phase(380);

    set_config(65000, 65000, 65000, 65000, 65000);
    repeat (6) noise_burst();
    drain();

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dsrc_pkg.sv
rtl/dsrc_line.sv
rtl/dsrc_ctrl.sv
rtl/door_scan_request_controller_unit.sv
rtl/dsrc_checker.sv
dv/door_scan_request_controller_unit_test.sv
